>>> sv/cte_pkg.sv
// Shared types and constants for the gap-buffer line editor.
// Has no dependencies. The interfaces, the RAM, the core and the checker import it.
package cte_pkg;

   // Fixed field widths of the request and response items.
   localparam int unsigned CMD_W     = 3;
   localparam int unsigned CHAR_W    = 8;
   localparam int unsigned POS_W     = 10;
   localparam int unsigned OUT_CNT_W = 11;

   // Default size of the character memory.
   localparam int unsigned BUFFER_DEPTH_DEF = 1024;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_BACK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

endpackage

>>> sv/cte_if.sv
// Valid/ready channel interfaces for the editor's request and response items.
// Depends on cte_pkg for the field widths.
interface cte_req_if import cte_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [CHAR_W-1:0] char_in;
   logic [POS_W-1:0]  read_pos;

   modport source (output valid, cmd, char_in, read_pos, input ready);
   modport sink   (input valid, cmd, char_in, read_pos, output ready);
endinterface

interface cte_rsp_if import cte_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 accepted;
   logic [CHAR_W-1:0]    char_out;
   logic [OUT_CNT_W-1:0] cursor_pos;
   logic [OUT_CNT_W-1:0] text_length;

   modport source (output valid, accepted, char_out, cursor_pos, text_length, input ready);
   modport sink   (input valid, accepted, char_out, cursor_pos, text_length, output ready);
endinterface

>>> sv/cte_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// No dependencies beyond the package import convention.
module cte_ram import cte_pkg::*; #(
   parameter int unsigned WIDTH = CHAR_W,
   parameter int unsigned DEPTH = BUFFER_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read data only changes on a read, so it holds while the port is idle.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/cursor_text_buffer_editor_core.sv
// Top level of the gap-buffer line editor: command decode, counters and memory sequencing.
// Depends on cte_pkg, the cte_req_if/cte_rsp_if interfaces and cte_ram.
//
// Usage:
//   The req_chan channel carries one command item: cmd (move left, move right,
//   backspace, insert, read by position), char_in for inserts and read_pos for
//   reads. The rsp_chan channel returns exactly one item per command: accepted,
//   char_out (nonzero only for a valid read), cursor_pos and text_length.
//   Both channels transfer an item when valid and ready are high at a clock edge.
//
// Timing:
//   The text lives in one single-port RAM with a registered read port. An
//   item is taken in the idle state, where the RAM is read (or written for an
//   insert); in the data state that follows, once the response register is
//   free, the read data is written back for cursor moves and the response is
//   loaded into the output register. A new item is taken only after the
//   previous one has left the data state, as the single port is shared.
//
// Reset and stalls:
//   Synchronous reset empties the line (cursor and length zero) and drops any
//   pending response; the RAM contents are not cleared. While the receiver
//   holds off, the response register keeps its item, and a following command
//   may be accepted and waits in the data state until the register frees up.
module cursor_text_buffer_editor_core import cte_pkg::*; #(
   parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cte_req_if.sink   req_chan,
   cte_rsp_if.source rsp_chan
);

   localparam int unsigned ADDR_W = $clog2(BUFFER_DEPTH);
   localparam int unsigned CNT_W  = $clog2(BUFFER_DEPTH + 1);
   localparam int unsigned CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic {
      S_IDLE,
      S_DATA
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      lc_ff, lc_in;
   logic [CNT_W-1:0]      rc_ff, rc_in;
   logic                  move_ff, move_in;
   logic                  read_ff, read_in;
   logic                  ok_ff, ok_in;
   logic [ADDR_W-1:0]     wr_addr_ff, wr_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_accepted_ff, rsp_accepted_in;
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic [OUT_CNT_W-1:0]  rsp_cursor_ff, rsp_cursor_in;
   logic [OUT_CNT_W-1:0]  rsp_length_ff, rsp_length_in;

   logic                  ram_en;
   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_addr;
   logic [CHAR_W-1:0]     ram_wdata;
   logic [CHAR_W-1:0]     ram_rdata;

   logic [CNT_W-1:0]      len;
   logic                  full;
   logic [CNT_W-1:0]      right_top;
   logic [CMP_W-1:0]      pos_x;
   logic [CMP_W-1:0]      lc_x;
   logic [CMP_W-1:0]      rc_x;
   logic [CMP_W-1:0]      right_off;
   logic [CMP_W-1:0]      right_addr;
   logic                  slot_free;

   cte_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_char_store (
      .clock   (clock),
      .en      (ram_en),
      .we      (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   // Address arithmetic on the two stacks.
   assign len        = lc_ff + rc_ff;
   assign full       = (len == CNT_W'(BUFFER_DEPTH));
   assign right_top  = CNT_W'(BUFFER_DEPTH) - rc_ff;
   assign pos_x      = CMP_W'(req_chan.read_pos);
   assign lc_x       = CMP_W'(lc_ff);
   assign rc_x       = CMP_W'(rc_ff);
   assign right_off  = pos_x - lc_x;
   assign right_addr = CMP_W'(BUFFER_DEPTH) - rc_x + right_off;

   // The response register can take a new item if empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // A new command is only taken once the previous one has finished its
   // write-back, so two RAM accesses to the same entry never overlap.
   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in        = state_ff;
      lc_in           = lc_ff;
      rc_in           = rc_ff;
      move_in         = move_ff;
      read_in         = read_ff;
      ok_in           = ok_ff;
      wr_addr_in      = wr_addr_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_char_in     = rsp_char_ff;
      rsp_cursor_in   = rsp_cursor_ff;
      rsp_length_in   = rsp_length_ff;
      ram_en          = 1'b0;
      ram_we          = 1'b0;
      ram_addr        = '0;
      ram_wdata       = req_chan.char_in;

      // Drain the response register when the receiver takes the item.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               state_in = S_DATA;
               move_in  = 1'b0;
               read_in  = 1'b0;
               ok_in    = 1'b0;
               case (req_chan.cmd)
                  CMD_LEFT: begin
                     // Pop the left stack top, push it onto the right stack.
                     if (lc_ff != '0) begin
                        ok_in      = 1'b1;
                        move_in    = 1'b1;
                        ram_en     = 1'b1;
                        ram_addr   = ADDR_W'(lc_ff - 1'b1);
                        wr_addr_in = ADDR_W'(right_top - 1'b1);
                        lc_in      = lc_ff - 1'b1;
                        rc_in      = rc_ff + 1'b1;
                     end
                  end
                  CMD_RIGHT: begin
                     // Pop the right stack top, push it onto the left stack.
                     if (rc_ff != '0) begin
                        ok_in      = 1'b1;
                        move_in    = 1'b1;
                        ram_en     = 1'b1;
                        ram_addr   = ADDR_W'(right_top);
                        wr_addr_in = ADDR_W'(lc_ff);
                        lc_in      = lc_ff + 1'b1;
                        rc_in      = rc_ff - 1'b1;
                     end
                  end
                  CMD_BACK: begin
                     if (lc_ff != '0) begin
                        ok_in = 1'b1;
                        lc_in = lc_ff - 1'b1;
                     end
                  end
                  CMD_INSERT: begin
                     if (!full) begin
                        ok_in    = 1'b1;
                        ram_en   = 1'b1;
                        ram_we   = 1'b1;
                        ram_addr = ADDR_W'(lc_ff);
                        lc_in    = lc_ff + 1'b1;
                     end
                  end
                  CMD_READ: begin
                     // Positions left of the cursor map directly; the rest
                     // index into the right stack from its top.
                     read_in = 1'b1;
                     if (pos_x < lc_x) begin
                        ok_in    = 1'b1;
                        ram_en   = 1'b1;
                        ram_addr = ADDR_W'(pos_x);
                     end else if (right_off < rc_x) begin
                        ok_in    = 1'b1;
                        ram_en   = 1'b1;
                        ram_addr = ADDR_W'(right_addr);
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         S_DATA: begin
            // Write back the moved character and load the response.
            if (slot_free) begin
               if (move_ff) begin
                  ram_en    = 1'b1;
                  ram_we    = 1'b1;
                  ram_addr  = wr_addr_ff;
                  ram_wdata = ram_rdata;
               end
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = ok_ff;
               rsp_char_in     = (read_ff && ok_ff) ? ram_rdata : '0;
               rsp_cursor_in   = OUT_CNT_W'(lc_ff);
               rsp_length_in   = OUT_CNT_W'(len);
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lc_ff        <= '0;
         rc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lc_ff        <= lc_in;
         rc_ff        <= rc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      move_ff         <= move_in;
      read_ff         <= read_in;
      ok_ff           <= ok_in;
      wr_addr_ff      <= wr_addr_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_length_ff   <= rsp_length_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.accepted    = rsp_accepted_ff;
   assign rsp_chan.char_out    = rsp_char_ff;
   assign rsp_chan.cursor_pos  = rsp_cursor_ff;
   assign rsp_chan.text_length = rsp_length_ff;

endmodule

>>> sv/cte_checker.sv
// Port-level checker for the gap-buffer line editor, bound to its top level.
// Depends on cte_pkg and cursor_text_buffer_editor_core.
module cte_checker import cte_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_accepted,
   input logic [CHAR_W-1:0]    rsp_char_out,
   input logic [OUT_CNT_W-1:0] rsp_cursor_pos,
   input logic [OUT_CNT_W-1:0] rsp_text_length
);

   // A response held back by the receiver keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_out)
         && $stable(rsp_cursor_pos) && $stable(rsp_text_length))
      else $error("stalled response item changed");

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // The cursor never lies beyond the end of the text.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cursor_pos <= rsp_text_length)
      else $error("cursor beyond text length");

   // A rejected item returns a zero character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_char_out == '0)
      else $error("character returned by a rejected item");

   // With the output register empty, the response is loaded in the data state.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |-> ##2 rsp_valid)
      else $error("response did not arrive two cycles after acceptance");

endmodule

bind cursor_text_buffer_editor_core cte_checker u_cte_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_accepted    (rsp_chan.accepted),
   .rsp_char_out    (rsp_chan.char_out),
   .rsp_cursor_pos  (rsp_chan.cursor_pos),
   .rsp_text_length (rsp_chan.text_length)
);

>>> sim/tb_cursor_text_buffer_editor_core.sv
// Self-checking testbench for the gap-buffer line editor core.
// Depends on cte_pkg, the cte_req_if/cte_rsp_if interfaces and the editor RTL.
// A local gap-buffer predictor supplies the expected response for every command item.
module tb_cursor_text_buffer_editor_core;
   import cte_pkg::*;

   localparam int unsigned CLK_PERIOD       = 12;
   localparam int unsigned TIMEOUT_CYCLES   = 400000;
   localparam int unsigned DEPTH            = BUFFER_DEPTH_DEF;
   localparam int unsigned POS_MAX          = (1 << POS_W) - 1;
   localparam int unsigned LONG_HOLD_CYCLES = 80;
   localparam int unsigned DRAIN_CYCLES     = 8;

   // Command codes that the block must ignore.
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic                 accepted;
      logic [CHAR_W-1:0]    char_out;
      logic [OUT_CNT_W-1:0] cursor_pos;
      logic [OUT_CNT_W-1:0] text_length;
   } edit_result_type;

   logic clock;
   logic reset;

   cte_req_if req_bus ();
   cte_rsp_if rsp_bus ();

   cursor_text_buffer_editor_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Predicted copy of the line: left stack from the bottom, right stack from the top.
   logic [CHAR_W-1:0] text_mem [0:DEPTH-1];
   int unsigned       left_n;
   int unsigned       right_n;

   edit_result_type pending_results [$];

   int unsigned mismatch_count;
   int unsigned items_sent;
   int unsigned results_checked;
   int unsigned peak_length;
   int unsigned full_rejects;
   bit          gaps_on;
   bit          stalls_on;
   bit          hold_req;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Applies one command to the predicted line and returns the response it should give.
   function automatic edit_result_type predict_edit(logic [CMD_W-1:0] cmd,
                                                    logic [CHAR_W-1:0] ch,
                                                    logic [POS_W-1:0] pos);
      edit_result_type r;
      int unsigned     p;
      r = '0;
      p = pos;
      case (cmd)
         CMD_LEFT: begin
            if (left_n > 0) begin
               left_n--;
               right_n++;
               text_mem[DEPTH - right_n] = text_mem[left_n];
               r.accepted = 1'b1;
            end
         end
         CMD_RIGHT: begin
            if (right_n > 0) begin
               text_mem[left_n] = text_mem[DEPTH - right_n];
               left_n++;
               right_n--;
               r.accepted = 1'b1;
            end
         end
         CMD_BACK: begin
            if (left_n > 0) begin
               left_n--;
               r.accepted = 1'b1;
            end
         end
         CMD_INSERT: begin
            if (left_n + right_n < DEPTH) begin
               text_mem[left_n] = ch;
               left_n++;
               r.accepted = 1'b1;
            end else begin
               full_rejects++;
            end
         end
         CMD_READ: begin
            if (p < left_n) begin
               r.char_out = text_mem[p];
               r.accepted = 1'b1;
            end else if (p - left_n < right_n) begin
               r.char_out = text_mem[DEPTH - right_n + (p - left_n)];
               r.accepted = 1'b1;
            end
         end
         default: ;
      endcase
      r.cursor_pos  = left_n[OUT_CNT_W-1:0];
      r.text_length = OUT_CNT_W'(left_n + right_n);
      if (left_n + right_n > peak_length) peak_length = left_n + right_n;
      return r;
   endfunction

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      mismatch_count++;
      $display("MISMATCH @%0t: %s expected %0d, got %0d", $time, what, want, got);
   endtask

   // Offers one command item, waits for its handshake and records the expected response.
   task automatic send_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                               logic [POS_W-1:0] pos);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= cmd;
      req_bus.char_in  <= ch;
      req_bus.read_pos <= pos;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(predict_edit(cmd, ch, pos));
      items_sent++;
   endtask

   // Stops offering items and waits until every expected response has arrived.
   task automatic wait_all_results();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Sends one random command; insert_pct sets how strongly the text grows.
   task automatic send_random_edit(int unsigned insert_pct);
      int unsigned      roll;
      int unsigned      len;
      int unsigned      p;
      logic [CMD_W-1:0] cmd;
      roll = $urandom_range(0, 99);
      len  = left_n + right_n;
      if (roll < insert_pct) begin
         cmd = CMD_INSERT;
      end else begin
         roll = $urandom_range(0, 19);
         if (roll < 5)       cmd = CMD_LEFT;
         else if (roll < 10) cmd = CMD_RIGHT;
         else if (roll < 14) cmd = CMD_BACK;
         else if (roll < 19) cmd = CMD_READ;
         else                cmd = CMD_SPARE_FIRST + CMD_W'($urandom_range(0, 2));
      end
      // Reads mostly land inside the text or just past its end.
      if ($urandom_range(0, 3) != 0) begin
         p = $urandom_range(0, len);
         if (p > POS_MAX) p = POS_MAX;
      end else begin
         p = $urandom_range(0, POS_MAX);
      end
      send_command(cmd, CHAR_W'($urandom), POS_W'(p));
   endtask

   // Boundary moves, deletes and reads on an empty line, plus the ignored codes.
   task automatic test_empty_line();
      send_command(CMD_LEFT, 8'h00, '0);
      send_command(CMD_RIGHT, 8'hFF, '1);
      send_command(CMD_BACK, 8'h00, '0);
      send_command(CMD_READ, 8'h00, '0);
      send_command(CMD_READ, 8'hFF, POS_W'(POS_MAX));
      for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
         send_command(CMD_SPARE_FIRST + CMD_W'(c - CMD_SPARE_FIRST), 8'hA5, '1);
      wait_all_results();
   endtask

   // Inserts of extreme and letter bytes, a zero byte among them, then reads.
   task automatic test_insert_and_read();
      send_command(CMD_INSERT, 8'h00, '0);
      send_command(CMD_INSERT, 8'hFF, '0);
      send_command(CMD_INSERT, "L", '0);
      send_command(CMD_INSERT, "D", '0);
      send_command(CMD_INSERT, "B", '0);
      send_command(CMD_INSERT, "P", '0);
      send_command(CMD_READ, 8'h00, POS_W'(0));
      send_command(CMD_READ, 8'h00, POS_W'(5));
      send_command(CMD_READ, 8'h00, POS_W'(6));
      wait_all_results();
   endtask

   // Cursor moves across the gap, a read on the right side and a right boundary.
   task automatic test_cursor_moves();
      send_command(CMD_LEFT, 8'h00, '0);
      send_command(CMD_LEFT, 8'h00, '0);
      send_command(CMD_READ, 8'h00, POS_W'(4));
      send_command(CMD_RIGHT, 8'h00, '0);
      send_command(CMD_BACK, 8'h00, '0);
      send_command(CMD_RIGHT, 8'h00, '0);
      send_command(CMD_RIGHT, 8'h00, '0);
      wait_all_results();
   endtask

   // A random mix of edits on a short line, so boundaries are hit often.
   task automatic test_random_edits();
      repeat (150) send_random_edit(30);
      wait_all_results();
   endtask

   // The receiver holds off while the sender keeps offering items back to back.
   task automatic test_backpressure();
      gaps_on  = 1'b0;
      hold_req = 1'b1;
      repeat (20) send_random_edit(40);
      wait_all_results();
      gaps_on = 1'b1;
   endtask

   // Grows the line to a full buffer with random bytes and some cursor motion.
   task automatic test_fill_buffer();
      while (left_n + right_n < DEPTH) send_random_edit(90);
      wait_all_results();
   endtask

   // Works at and near a full buffer, back to back with no idling.
   task automatic test_full_buffer();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      send_command(CMD_INSERT, 8'h5A, '0);
      send_command(CMD_READ, 8'h00, POS_W'(POS_MAX));
      repeat (80) send_random_edit(50);
      wait_all_results();
   endtask

   // Response checker: each response item is compared with the oldest expectation.
   always @(posedge clock) begin : check_results
      edit_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response item, accepted", 0, rsp_bus.accepted);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_bus.accepted !== want.accepted)
               report_mismatch("accepted", want.accepted, rsp_bus.accepted);
            if (rsp_bus.char_out !== want.char_out)
               report_mismatch("char_out", want.char_out, rsp_bus.char_out);
            if (rsp_bus.cursor_pos !== want.cursor_pos)
               report_mismatch("cursor_pos", want.cursor_pos, rsp_bus.cursor_pos);
            if (rsp_bus.text_length !== want.text_length)
               report_mismatch("text_length", want.text_length, rsp_bus.text_length);
         end
      end
   end

   // Response ready: random stall bursts, and one long hold-off on request.
   initial begin : drive_ready
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog for a hung handshake.
   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("Verification failed");
      $finish;
   end

   // Main sequence.
   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.cmd      = CMD_LEFT;
      req_bus.char_in  = '0;
      req_bus.read_pos = '0;
      left_n           = 0;
      right_n          = 0;
      mismatch_count   = 0;
      items_sent       = 0;
      results_checked  = 0;
      peak_length      = 0;
      full_rejects     = 0;
      gaps_on          = 1'b1;
      stalls_on        = 1'b1;
      hold_req         = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_line();
      test_insert_and_read();
      test_cursor_moves();
      test_random_edits();
      test_backpressure();
      test_fill_buffer();
      test_full_buffer();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("responses still missing", 0, pending_results.size());

      $display("Sent %0d commands and checked %0d responses.", items_sent, results_checked);
      $display("Text reached %0d of %0d characters; %0d inserts hit a full buffer.",
               peak_length, DEPTH, full_rejects);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
